@@ rtl/psu_pkg.sv @@
// Shared types, constants and codes of the PNG scanline unfilter.
package psu_pkg;

	localparam int MaxRowBytes   = 8192;
	localparam int MaxPixelBytes = 8;
	localparam int AddrW         = $clog2(MaxRowBytes);
	localparam int TapW          = (MaxPixelBytes > 1) ? $clog2(MaxPixelBytes) : 1;
	localparam int WidthW        = 14;
	localparam int HeightW       = 16;
	localparam int DepthW        = 5;
	localparam int KindW         = 3;
	localparam int BppW          = 7;
	localparam int ProdW         = BppW + WidthW;
	localparam int LenW          = ProdW + 1 - 3;
	localparam int CfgIdxW       = 2;
	localparam int CfgDataW      = 16;

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filter_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_DEPTH  = 2'd2,
		CFG_KIND   = 2'd3
	} cfg_index_t;

	localparam logic [KindW-1:0] KIND_RGB  = 3'd2;
	localparam logic [KindW-1:0] KIND_GA   = 3'd4;
	localparam logic [KindW-1:0] KIND_RGBA = 3'd6;
	localparam logic [7:0]       MaxFilterCode = 8'd4;

	typedef struct packed {
		logic [7:0] encoded_byte;
		logic       frame_start;
	} in_word_t;

	typedef struct packed {
		logic [7:0] pixel_byte;
		logic       row_end;
		logic       image_end;
		logic       bad_filter;
		logic       row_too_long;
	} out_word_t;

	typedef struct packed {
		filter_t             filter;
		logic                up_ok;
		logic                store;
		logic [AddrW-1:0]    addr;
		logic [TapW-1:0]     tap;
		logic                row_end;
		logic                image_end;
		logic                bad_filter;
		logic                row_too_long;
	} ctl_t;

endpackage

@@ rtl/psu_line_ram.sv @@
// Simple dual-port line RAM with a registered read port.
module psu_line_ram #(
	parameter int DEPTH = 8192,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/psu_seq.sv @@
// Configuration registers, row geometry and row and column sequencing.
module psu_seq
	import psu_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                fire,
	input  in_word_t            word,
	output logic                is_data,
	output ctl_t                ctl
);

	logic [WidthW-1:0]  width_q;
	logic [HeightW-1:0] height_q;
	logic [DepthW-1:0]  depth_q;
	logic [KindW-1:0]   kind_q;

	logic [HeightW-1:0] row_q;
	logic [LenW-1:0]    col_q;
	filter_t            filter_q;
	logic               bad_q;
	logic               awaiting_q;

	logic [2:0]         mult;
	logic [7:0]         bpp_full;
	logic [BppW-1:0]    bpp;
	logic [ProdW-1:0]   prod;
	logic [ProdW:0]     prod_rnd;
	logic [LenW-1:0]    len_raw;
	logic [LenW-1:0]    row_len;
	logic [4:0]         stride_raw;
	logic [4:0]         stride;
	logic [HeightW-1:0] height;
	logic [HeightW-1:0] row_eff;
	logic               awaiting;
	logic               last_col;
	logic               last_row;
	logic               in_store;
	logic               bad_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WidthW'(1);
			height_q <= HeightW'(1);
			depth_q  <= DepthW'(8);
			kind_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_WIDTH:  width_q  <= cfg_data[WidthW-1:0];
				CFG_HEIGHT: height_q <= cfg_data[HeightW-1:0];
				CFG_DEPTH:  depth_q  <= cfg_data[DepthW-1:0];
				CFG_KIND:   kind_q   <= cfg_data[KindW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (kind_q)
			KIND_RGB:  mult = 3'd3;
			KIND_GA:   mult = 3'd2;
			KIND_RGBA: mult = 3'd4;
			default:   mult = 3'd1;
		endcase
		bpp_full   = 8'(depth_q) * 8'(mult);
		bpp        = bpp_full[BppW-1:0];
		prod       = ProdW'(bpp) * ProdW'(width_q);
		prod_rnd   = {1'b0, prod} + (ProdW + 1)'(7);
		len_raw    = prod_rnd[ProdW:3];
		row_len    = (len_raw == '0) ? LenW'(1) : len_raw;
		stride_raw = 5'(({1'b0, bpp} + 8'd7) >> 3);
		if (stride_raw == 5'd0) begin
			stride = 5'd1;
		end else if (32'(stride_raw) > MaxPixelBytes) begin
			stride = 5'(MaxPixelBytes);
		end else begin
			stride = stride_raw;
		end
		height   = (height_q == '0) ? HeightW'(1) : height_q;
		awaiting = awaiting_q | word.frame_start;
		row_eff  = word.frame_start ? '0 : row_q;
		last_col = ({1'b0, col_q} + (LenW + 1)'(1)) >= {1'b0, row_len};
		last_row = ({1'b0, row_eff} + (HeightW + 1)'(1)) >= {1'b0, height};
		in_store = 32'(col_q) < MaxRowBytes;
		bad_code = word.encoded_byte > MaxFilterCode;
		is_data  = !awaiting;
	end

	always_comb begin
		ctl.filter       = filter_q;
		ctl.up_ok        = (row_q != '0) && in_store;
		ctl.store        = in_store;
		ctl.addr         = col_q[AddrW-1:0];
		ctl.tap          = TapW'(stride - 5'd1);
		ctl.row_end      = last_col;
		ctl.image_end    = last_col && last_row;
		ctl.bad_filter   = bad_q;
		ctl.row_too_long = 32'(row_len) > MaxRowBytes;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			filter_q   <= FILT_NONE;
			bad_q      <= 1'b0;
			awaiting_q <= 1'b1;
		end else if (fire) begin
			if (awaiting) begin
				bad_q      <= bad_code;
				filter_q   <= bad_code ? FILT_NONE : filter_t'(word.encoded_byte[2:0]);
				col_q      <= '0;
				row_q      <= row_eff;
				awaiting_q <= 1'b0;
			end else if (last_col) begin
				awaiting_q <= 1'b1;
				col_q      <= '0;
				row_q      <= last_row ? '0 : row_q + HeightW'(1);
			end else begin
				col_q <= col_q + LenW'(1);
			end
		end
	end

endmodule

@@ rtl/psu_recon.sv @@
// Predictor stage, left and upper-left histories and output register.
module psu_recon
	import psu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             data_fire,
	input  logic             clear_hist,
	input  ctl_t             ctl,
	input  logic [7:0]       enc_byte,
	input  logic [7:0]       up_byte,
	output logic             ready,
	output logic             ram_we,
	output logic [AddrW-1:0] ram_waddr,
	output logic [7:0]       ram_wdata,
	output logic             out_valid,
	input  logic             out_stall,
	output out_word_t        out_word
);

	logic       s1_valid_q;
	ctl_t       ctl_s1;
	logic [7:0] byte_s1;
	logic [7:0] left_q   [MaxPixelBytes];
	logic [7:0] upleft_q [MaxPixelBytes];

	logic       out_free;
	logic       s1_adv;
	logic [7:0] a;
	logic [7:0] b;
	logic [7:0] c;
	logic [8:0] avg_sum;
	logic [7:0] pred;
	logic [7:0] val;

	function automatic logic [7:0] paeth(input logic [7:0] pa_in, input logic [7:0] pb_in,
			input logic [7:0] pc_in);
		logic signed [9:0] da;
		logic signed [9:0] db;
		logic signed [9:0] dc;
		logic [9:0]        abs_a;
		logic [9:0]        abs_b;
		logic [9:0]        abs_c;
		logic [7:0]        res;
		da    = $signed({2'b00, pb_in}) - $signed({2'b00, pc_in});
		db    = $signed({2'b00, pa_in}) - $signed({2'b00, pc_in});
		dc    = da + db;
		abs_a = (da < 0) ? 10'(-da) : 10'(da);
		abs_b = (db < 0) ? 10'(-db) : 10'(db);
		abs_c = (dc < 0) ? 10'(-dc) : 10'(dc);
		if (abs_a <= abs_b && abs_a <= abs_c) begin
			res = pa_in;
		end else if (abs_b <= abs_c) begin
			res = pb_in;
		end else begin
			res = pc_in;
		end
		return res;
	endfunction

	assign out_free = !out_valid || !out_stall;
	assign s1_adv   = s1_valid_q && out_free;
	assign ready    = !s1_valid_q || out_free;

	always_comb begin
		b       = ctl_s1.up_ok ? up_byte : 8'd0;
		a       = left_q[ctl_s1.tap];
		c       = upleft_q[ctl_s1.tap];
		avg_sum = {1'b0, a} + {1'b0, b};
		case (ctl_s1.filter)
			FILT_SUB:   pred = a;
			FILT_UP:    pred = b;
			FILT_AVG:   pred = avg_sum[8:1];
			FILT_PAETH: pred = paeth(a, b, c);
			default:    pred = 8'd0;
		endcase
		val = byte_s1 + pred;
	end

	assign ram_we    = s1_adv && ctl_s1.store;
	assign ram_waddr = ctl_s1.addr;
	assign ram_wdata = val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (data_fire) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (data_fire) begin
			ctl_s1  <= ctl;
			byte_s1 <= enc_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MaxPixelBytes; k++) begin
				left_q[k]   <= 8'd0;
				upleft_q[k] <= 8'd0;
			end
		end else if (clear_hist) begin
			for (int k = 0; k < MaxPixelBytes; k++) begin
				left_q[k]   <= 8'd0;
				upleft_q[k] <= 8'd0;
			end
		end else if (s1_adv) begin
			for (int k = MaxPixelBytes - 1; k > 0; k--) begin
				left_q[k]   <= left_q[k-1];
				upleft_q[k] <= upleft_q[k-1];
			end
			left_q[0]   <= val;
			upleft_q[0] <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_word.pixel_byte   <= val;
			out_word.row_end      <= ctl_s1.row_end;
			out_word.image_end    <= ctl_s1.image_end;
			out_word.bad_filter   <= ctl_s1.bad_filter;
			out_word.row_too_long <= ctl_s1.row_too_long;
		end
	end

endmodule

@@ rtl/png_scanline_unfilter.sv @@
// Top level of the PNG scanline unfilter: one stream byte in, at most one raw byte out.
//
//   channel   handshake              word
//   enc       enc_valid / enc_stall  in_word_t  : filtered byte, frame start
//   pix       pix_valid / pix_stall  out_word_t : raw byte and row flags
//   cfg       cfg_we                 cfg_index, cfg_data
//
// One byte is taken per cycle unless a stall on pix holds enc; a data byte is registered
// in the predictor stage and then in the output register before it is offered on pix.
// The rate is set by the single line-store read per byte and the write-back of the
// rebuilt byte from the predictor stage; a filter byte separates the rows, so the two
// never touch the same entry in the same cycle. Filter bytes give no output word.
// Reset clears counters and histories (not the line store) and sets configuration defaults.
// A stall on pix holds the output register, then the predictor stage, then enc.
module png_scanline_unfilter
	import psu_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                enc_valid,
	output logic                enc_stall,
	input  in_word_t            enc_word,
	output logic                pix_valid,
	input  logic                pix_stall,
	output out_word_t           pix_word,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	logic             ready;
	logic             fire;
	logic             is_data;
	logic             data_fire;
	logic             clear_hist;
	ctl_t             ctl;
	logic             ram_we;
	logic [AddrW-1:0] ram_waddr;
	logic [7:0]       ram_wdata;
	logic [7:0]       up_byte;

	assign enc_stall  = !ready;
	assign fire       = enc_valid && ready;
	assign data_fire  = fire && is_data;
	assign clear_hist = fire && !is_data;

	psu_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fire      (fire),
		.word      (enc_word),
		.is_data   (is_data),
		.ctl       (ctl)
	);

	psu_line_ram #(
		.DEPTH (MaxRowBytes),
		.WIDTH (8)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (data_fire && ctl.store),
		.raddr (ctl.addr),
		.rdata (up_byte)
	);

	psu_recon u_recon (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_fire  (data_fire),
		.clear_hist (clear_hist),
		.ctl        (ctl),
		.enc_byte   (enc_word.encoded_byte),
		.up_byte    (up_byte),
		.ready      (ready),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.out_valid  (pix_valid),
		.out_stall  (pix_stall),
		.out_word   (pix_word)
	);

endmodule

@@ sim/tb_png_scanline_unfilter.sv @@
// Testbench for png_scanline_unfilter: directed and random byte streams checked against a predictor.
`timescale 1ns / 1ps

module tb_png_scanline_unfilter;
	import psu_pkg::*;

	localparam int QuietLimit = 4000;

	typedef struct packed {
		logic       reg_row;
		cfg_index_t reg_idx;
		logic [15:0] reg_val;
		in_word_t   word;
		logic       typed;
		logic       has_pix;
		out_word_t  pix;
	} step_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                enc_valid = 1'b0;
	logic                enc_stall;
	in_word_t            enc_word = '0;
	logic                pix_valid;
	logic                pix_stall = 1'b0;
	out_word_t           pix_word;
	logic                cfg_we = 1'b0;
	cfg_index_t          cfg_index = CFG_WIDTH;
	logic [CfgDataW-1:0] cfg_data = '0;

	logic [13:0] cfg_width = 14'd1;
	logic [15:0] cfg_height = 16'd1;
	logic [4:0]  cfg_depth = 5'd8;
	logic [2:0]  cfg_kind = 3'd0;
	logic [7:0]  line_mem [MaxRowBytes];
	logic [7:0]  left_hist [MaxPixelBytes];
	logic [7:0]  upl_hist [MaxPixelBytes];
	int unsigned row_idx = 0;
	int unsigned col_idx = 0;
	filter_t     cur_filt = FILT_NONE;
	bit          bad_code = 1'b0;
	bit          want_code = 1'b1;

	out_word_t pix_expect [$];
	out_word_t head;
	int        mismatches = 0;
	int        words_sent = 0;
	int        hold_off = 0;
	bit        steady = 1'b0;
	int        colour_kinds [5] = '{0, KIND_RGB, 3, KIND_GA, KIND_RGBA};

	png_scanline_unfilter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.enc_valid(enc_valid),
		.enc_stall(enc_stall),
		.enc_word(enc_word),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix_word(pix_word),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int pixel_bits(int d, int k);
		int mult;
		mult = 1;
		if (k == KIND_RGB) mult = 3;
		else if (k == KIND_GA) mult = 2;
		else if (k == KIND_RGBA) mult = 4;
		return d * mult;
	endfunction

	function automatic int row_bytes(int bpp, int w);
		int n;
		n = (bpp * w + 7) / 8;
		return (n == 0) ? 1 : n;
	endfunction

	task automatic unfilter(input in_word_t w, output bit made, output out_word_t res);
		int bpp, len, stride, height, a, b, c, pred, p, pa, pb, pc, k;
		logic [7:0] val;
		bit last_col, last_row;
		bpp = pixel_bits(int'(cfg_depth), int'(cfg_kind));
		len = row_bytes(bpp, int'(cfg_width));
		stride = (bpp + 7) / 8;
		if (stride == 0) stride = 1;
		if (stride > MaxPixelBytes) stride = MaxPixelBytes;
		height = (cfg_height == 0) ? 1 : int'(cfg_height);
		made = 1'b0;
		res = '0;
		if (w.frame_start) begin
			row_idx = 0;
			want_code = 1'b1;
		end
		if (want_code) begin
			bad_code = w.encoded_byte > MaxFilterCode;
			cur_filt = bad_code ? FILT_NONE : filter_t'(w.encoded_byte[2:0]);
			col_idx = 0;
			for (k = 0; k < MaxPixelBytes; k++) begin
				left_hist[k] = 8'h00;
				upl_hist[k] = 8'h00;
			end
			want_code = 1'b0;
			return;
		end
		a = 0;
		b = 0;
		c = 0;
		if (row_idx != 0 && col_idx < MaxRowBytes) b = int'(line_mem[col_idx]);
		if (col_idx >= stride) begin
			a = int'(left_hist[stride-1]);
			c = int'(upl_hist[stride-1]);
		end
		case (cur_filt)
			FILT_SUB: pred = a;
			FILT_UP: pred = b;
			FILT_AVG: pred = (a + b) / 2;
			FILT_PAETH: begin
				p = a + b - c;
				pa = (p > a) ? p - a : a - p;
				pb = (p > b) ? p - b : b - p;
				pc = (p > c) ? p - c : c - p;
				pred = (pa <= pb && pa <= pc) ? a : (pb <= pc) ? b : c;
			end
			default: pred = 0;
		endcase
		val = 8'(int'(w.encoded_byte) + pred);
		for (k = MaxPixelBytes - 1; k > 0; k--) begin
			left_hist[k] = left_hist[k-1];
			upl_hist[k] = upl_hist[k-1];
		end
		left_hist[0] = val;
		upl_hist[0] = 8'(b);
		if (col_idx < MaxRowBytes) line_mem[col_idx] = val;
		last_col = col_idx + 1 >= len;
		last_row = row_idx + 1 >= height;
		res.pixel_byte = val;
		res.row_end = last_col;
		res.image_end = last_col && last_row;
		res.bad_filter = bad_code;
		res.row_too_long = len > MaxRowBytes;
		made = 1'b1;
		if (last_col) begin
			want_code = 1'b1;
			col_idx = 0;
			row_idx = last_row ? 0 : row_idx + 1;
		end else begin
			col_idx++;
		end
	endtask

	task automatic log_mismatch(string msg);
		if (mismatches < 100) $display("ERROR at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	function automatic int gap_len();
		int r;
		if (steady) return 0;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	task automatic send(in_word_t w, bit typed = 1'b0, bit has_pix = 1'b0,
			out_word_t pix = '0);
		bit made;
		out_word_t guess;
		int gap;
		enc_word <= w;
		enc_valid <= 1'b1;
		do @(posedge clk); while (enc_stall);
		unfilter(w, made, guess);
		if (typed ? has_pix : made) pix_expect.push_back(typed ? pix : guess);
		words_sent++;
		@(negedge clk);
		gap = gap_len();
		if (gap > 0) begin
			enc_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic settle();
		enc_valid <= 1'b0;
		while (pix_expect.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		case (idx)
			CFG_WIDTH: cfg_width = v[13:0];
			CFG_HEIGHT: cfg_height = v;
			CFG_DEPTH: cfg_depth = v[4:0];
			CFG_KIND: cfg_kind = v[2:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_geometry(int w, int h, int d, int k);
		write_reg(CFG_WIDTH, 16'(w));
		write_reg(CFG_HEIGHT, 16'(h));
		write_reg(CFG_DEPTH, 16'(d));
		write_reg(CFG_KIND, 16'(k));
	endtask

	task automatic random_geometry(int pick);
		int w, h, d, k;
		case (pick)
			0: begin
				d = 0;
				k = 7;
				w = 16383;
				h = 65535;
			end
			1: begin
				d = 31;
				k = KIND_RGBA;
				w = 1;
				h = 0;
			end
			default: begin
				d = ($urandom_range(4) != 0) ? (1 << $urandom_range(4)) : $urandom_range(31);
				k = ($urandom_range(3) != 0) ? colour_kinds[$urandom_range(4)] : $urandom_range(7);
				w = ($urandom_range(9) == 0) ? 16383 : $urandom_range(8);
				h = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(4);
				while (w > 1 && row_bytes(pixel_bits(d, k), w) > 40) w = w / 2;
			end
		endcase
		set_geometry(w, h, d, k);
	endtask

	task automatic send_image();
		int len, rows, cut, n, r, i;
		logic [7:0] code;
		len = row_bytes(pixel_bits(int'(cfg_depth), int'(cfg_kind)), int'(cfg_width));
		rows = (cfg_height > 4) ? $urandom_range(1, 3) : (cfg_height == 0) ? 1 : int'(cfg_height);
		cut = ($urandom_range(9) == 0) ? $urandom_range(0, rows * (len + 1) - 1) : -1;
		n = 0;
		for (r = 0; r < rows; r++) begin
			code = ($urandom_range(6) != 0) ? 8'($urandom_range(4)) : 8'($urandom_range(5, 255));
			if (n == cut) return;
			n++;
			send({code, (r == 0) && ($urandom_range(9) != 0)});
			for (i = 0; i < len; i++) begin
				if (n == cut) return;
				n++;
				send({8'($urandom_range(255)), 1'b0});
			end
		end
	endtask

	function automatic step_t code_in(logic [7:0] b, logic s);
		step_t st;
		st = '0;
		st.word = {b, s};
		st.typed = 1'b1;
		return st;
	endfunction

	function automatic step_t byte_out(logic [7:0] b, logic bad);
		step_t st;
		st = '0;
		st.word = {b, 1'b0};
		st.typed = 1'b1;
		st.has_pix = 1'b1;
		st.pix = {b, 1'b1, 1'b1, bad, 1'b0};
		return st;
	endfunction

	function automatic step_t data_in(logic [7:0] b, logic s);
		step_t st;
		st = '0;
		st.word = {b, s};
		return st;
	endfunction

	function automatic step_t reg_wr(cfg_index_t idx, logic [15:0] v);
		step_t st;
		st = '0;
		st.reg_row = 1'b1;
		st.reg_idx = idx;
		st.reg_val = v;
		return st;
	endfunction

	initial begin : receiver
		int left, r;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				left = hold_off;
				hold_off = 0;
			end else if (left == 0 && !steady) begin
				r = $urandom_range(99);
				if (r >= 93) left = $urandom_range(10, 40);
				else if (r >= 65) left = $urandom_range(1, 3);
			end
			pix_stall <= (left > 0);
			if (left > 0) left--;
		end
	end

	always @(posedge clk) begin : check_out
		if (arst_n && pix_valid && !pix_stall) begin
			if (pix_expect.size() == 0) begin
				log_mismatch($sformatf("output word %h with nothing expected", pix_word));
			end else begin
				head = pix_expect.pop_front();
				if (pix_word.pixel_byte !== head.pixel_byte)
					log_mismatch($sformatf("pixel_byte %h, expected %h",
						pix_word.pixel_byte, head.pixel_byte));
				if (pix_word.row_end !== head.row_end)
					log_mismatch($sformatf("row_end %b, expected %b",
						pix_word.row_end, head.row_end));
				if (pix_word.image_end !== head.image_end)
					log_mismatch($sformatf("image_end %b, expected %b",
						pix_word.image_end, head.image_end));
				if (pix_word.bad_filter !== head.bad_filter)
					log_mismatch($sformatf("bad_filter %b, expected %b",
						pix_word.bad_filter, head.bad_filter));
				if (pix_word.row_too_long !== head.row_too_long)
					log_mismatch($sformatf("row_too_long %b, expected %b",
						pix_word.row_too_long, head.row_too_long));
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QuietLimit) begin
			@(posedge clk);
			if ((enc_valid && !enc_stall) || (pix_valid && !pix_stall)) quiet = 0;
			else quiet++;
		end
		$display("png_scanline_unfilter test failed");
		$finish;
	end

	initial begin : stimulus
		step_t directed [$];
		int i, len, from, pick, n;
		directed = '{
			code_in(8'h00, 1'b1), byte_out(8'h00, 1'b0),
			code_in(8'(FILT_SUB), 1'b0), byte_out(8'hFF, 1'b0),
			code_in(8'(FILT_UP), 1'b0), byte_out(8'h80, 1'b0),
			code_in(8'(FILT_AVG), 1'b0), byte_out(8'h7F, 1'b0),
			code_in(8'(FILT_PAETH), 1'b1), byte_out(8'h55, 1'b0),
			code_in(8'h05, 1'b0), byte_out(8'hAA, 1'b1),
			code_in(8'hFF, 1'b1), byte_out(8'hC3, 1'b1),
			reg_wr(CFG_KIND, 16'(KIND_GA)), reg_wr(CFG_WIDTH, 16'd2), reg_wr(CFG_HEIGHT, 16'd3),
			data_in(8'(FILT_UP), 1'b1), data_in(8'h10, 1'b0), data_in(8'hF0, 1'b0),
			data_in(8'h33, 1'b0), data_in(8'hCC, 1'b0),
			data_in(8'(FILT_PAETH), 1'b0), data_in(8'h01, 1'b0), data_in(8'h80, 1'b0),
			data_in(8'hFE, 1'b0), data_in(8'h7F, 1'b0),
			data_in(8'(FILT_AVG), 1'b0), data_in(8'hFF, 1'b0), data_in(8'h00, 1'b0),
			data_in(8'h07, 1'b1), data_in(8'h3C, 1'b0)
		};
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (directed[j]) begin
			if (directed[j].reg_row) begin
				settle();
				write_reg(directed[j].reg_idx, directed[j].reg_val);
			end else begin
				send(directed[j].word, directed[j].typed, directed[j].has_pix, directed[j].pix);
			end
		end

		// Two rows longer than the line store; the first one also fills every entry.
		settle();
		set_geometry(4097, 2, 16, 0);
		len = row_bytes(pixel_bits(16, 0), 4097);
		send({8'(FILT_NONE), 1'b1});
		for (i = 0; i < len; i++) begin
			if (i == 100) hold_off = 250;
			send({8'($urandom_range(255)), 1'b0});
		end
		send({8'(FILT_UP), 1'b0});
		for (i = 0; i < len; i++) send({8'($urandom_range(255)), 1'b0});

		from = words_sent;
		pick = 0;
		while (words_sent < from + 850) begin
			if (pick < 2 || $urandom_range(2) == 0) begin
				settle();
				random_geometry(pick);
				pick++;
			end else if ($urandom_range(5) == 0) begin
				settle();
			end
			steady = ($urandom_range(4) == 0);
			if ($urandom_range(9) < 8) begin
				send_image();
			end else begin
				n = $urandom_range(1, 12);
				repeat (n) send({8'($urandom_range(255)), $urandom_range(7) == 0});
			end
		end
		steady = 1'b0;

		enc_valid <= 1'b0;
		while (pix_expect.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0) begin
			$display("png_scanline_unfilter test passed");
		end else begin
			$display("png_scanline_unfilter test failed");
		end
		$finish;
	end

endmodule
